>>> sv/bpr_pkg.sv
// Shared types and constants for the byte pipe ring FIFO.
package bpr_pkg;

  // Default geometry of the ring and the read burst limit.
  localparam int DEPTH_DEF    = 256;
  localparam int MAX_READ_DEF = 64;

  // Command codes carried by a request.
  typedef enum logic [1:0] {
    CMD_WRITE       = 2'd0,
    CMD_READ        = 2'd1,
    CMD_CLOSE_WRITE = 2'd2,
    CMD_CLOSE_READ  = 2'd3
  } cmd_t;

  // Status codes carried by a response.
  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_WROK   = 3'd1,
    ST_CLOSED = 3'd2,
    ST_EOF    = 3'd3,
    ST_AGAIN  = 3'd4,
    ST_PIPE   = 3'd5,
    ST_INVAL  = 3'd6
  } status_t;

  // Control states of the pipe.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // One request item.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wr_byte;
    logic [6:0] read_len;
    logic       abort_pending;
  } req_t;

  // One response item.
  typedef struct packed {
    status_t    status;
    logic [7:0] rd_byte;
    logic       last;
  } rsp_t;

endpackage

>>> sv/byte_pipe_ring_fifo_top.sv
// Byte pipe over a power-of-two ring buffer held in one synchronous memory.
//
// Requests arrive on the req channel (req_valid, req_stall, req) and responses
// leave on the rsp channel (rsp_valid, rsp_stall, rsp). A transfer happens on a
// rising edge where valid is high and stall is low.
// A write, a close or a refused read gives one response, registered, in the
// cycle after the request transfer; such requests can follow each other every
// cycle while the response side keeps taking transfers.
// A read streams one data response per byte, up to the requested length capped
// by MAX_READ and the bytes held, one per cycle while the receiver takes them,
// through the ring memory's read register and then the response register; the
// last one carries last. No request is taken during a burst.
// When the receiver stalls, the response register holds its transfer, no new
// memory read is issued beyond the one already in flight, and req_stall
// stays high until the response register can take a new result.
// Reset clears both pointers and both closed flags, and empties the response
// register. The ring contents are not cleared; only written slots are read.
module byte_pipe_ring_fifo_top #(
  parameter int DEPTH    = bpr_pkg::DEPTH_DEF,
  parameter int MAX_READ = bpr_pkg::MAX_READ_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bpr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bpr_pkg::rsp_t rsp
);
  import bpr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(MAX_READ + 1);
  localparam int LW = (AW > 7) ? AW : 7;

  // Ring storage and pointers.
  logic [7:0]    store [DEPTH];
  logic [7:0]    mem_q;
  logic [AW-1:0] write_ptr;
  logic [AW-1:0] read_ptr;
  logic          writer_done;
  logic          reader_done;

  // Read burst control.
  state_t        state;
  state_t        state_next;
  logic [CW-1:0] remaining;
  logic          rd_pend;
  logic          rd_last;

  // Handshake and datapath controls.
  logic          load;
  logic          accept;
  logic          issue;
  logic          drain;
  logic          mem_we;
  logic [AW-1:0] fill;
  logic          full;
  logic [6:0]    len_sat;
  logic [LW-1:0] count;
  logic          single;
  status_t       single_status;

  // The response register can take a new result this cycle.
  assign load = !rsp_valid || !rsp_stall;
  assign fill = write_ptr - read_ptr;
  assign full = (fill == {AW{1'b1}});
  assign accept = req_valid && !req_stall;
  assign drain = rd_pend && load;

  // Burst length: saturated request length limited by the bytes available.
  always_comb begin
    len_sat = (req.read_len > 7'(MAX_READ)) ? 7'(MAX_READ) : req.read_len;
    if (LW'(fill) < LW'(len_sat)) begin
      count = LW'(fill);
    end else begin
      count = LW'(len_sat);
    end
  end

  // Decode the single-result commands.
  always_comb begin
    single        = 1'b1;
    single_status = ST_CLOSED;
    mem_we        = 1'b0;
    unique case (req.cmd)
      CMD_WRITE: begin
        if (full && !reader_done) begin
          single_status = ST_AGAIN;
        end else if (reader_done || req.abort_pending) begin
          single_status = ST_PIPE;
        end else begin
          single_status = ST_WROK;
          mem_we        = accept;
        end
      end
      CMD_READ: begin
        if (req.read_len == 7'd0) begin
          single_status = ST_INVAL;
        end else if (fill == '0) begin
          single_status = writer_done ? ST_EOF : ST_AGAIN;
        end else begin
          single = 1'b0;
        end
      end
      CMD_CLOSE_WRITE, CMD_CLOSE_READ: begin
        single_status = ST_CLOSED;
      end
      default: begin
        single_status = ST_CLOSED;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !single) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (drain && rd_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    req_stall = 1'b1;
    issue     = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_stall = !load;
      end
      S_READ: begin
        issue = (remaining != '0) && (!rd_pend || load);
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[write_ptr] <= req.wr_byte;
    end
    if (issue) begin
      mem_q <= store[read_ptr];
    end
  end

  // Pointers, closed flags and burst counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr   <= '0;
      read_ptr    <= '0;
      writer_done <= 1'b0;
      reader_done <= 1'b0;
      remaining   <= '0;
      rd_pend     <= 1'b0;
      rd_last     <= 1'b0;
    end else begin
      if (mem_we) begin
        write_ptr <= write_ptr + 1'b1;
      end
      if (accept && req.cmd == CMD_CLOSE_WRITE) begin
        writer_done <= 1'b1;
      end
      if (accept && req.cmd == CMD_CLOSE_READ) begin
        reader_done <= 1'b1;
      end
      if (accept && !single) begin
        remaining <= CW'(count);
      end else if (issue) begin
        remaining <= remaining - 1'b1;
      end
      if (issue) begin
        read_ptr <= read_ptr + 1'b1;
        rd_pend  <= 1'b1;
        rd_last  <= (remaining == CW'(1));
      end else if (drain) begin
        rd_pend <= 1'b0;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= (accept && single) || rd_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      rsp.status  <= ST_DATA;
      rsp.rd_byte <= mem_q;
      rsp.last    <= rd_last;
    end else if (load && accept && single) begin
      rsp.status  <= single_status;
      rsp.rd_byte <= 8'd0;
      rsp.last    <= 1'b1;
    end
  end

  // A memory read in flight only exists during a burst.
  a_pend_in_read: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == S_READ)
    else $error("read in flight outside a burst");

  // A burst always has work left: bytes to fetch or a byte to deliver.
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> (remaining != '0 || rd_pend))
    else $error("burst stuck with nothing to do");

  // Delivering the final byte ends the burst.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (drain && rd_last) |=> state == S_IDLE)
    else $error("burst did not end after its last byte");

  // The ring never takes a byte while full.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !full)
    else $error("write into a full ring");

  // A delivered data byte leaves the response register valid next cycle.
  a_drain_out: assert property (@(posedge clk) disable iff (rst)
    drain |=> (rsp_valid && rsp.status == ST_DATA))
    else $error("burst byte lost on the response side");

endmodule
